// ----- hdl/slir_pkg.sv -----
package slir_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_REMOVED   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [4:0]         count;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_REM_RD,
    ST_REM_CMP,
    ST_HEAD,
    ST_TAIL,
    ST_TAIL_WAIT,
    ST_FIN
  } state_t;

endpackage

// ----- hdl/sorted_list_insert_remove_unit.sv -----
// channel | ports                        | direction | payload
// --------+------------------------------+-----------+-----------------------------
// command | in_valid, in_ready, in_data   | in        | slir_pkg::in_t (command, value)
// result  | out_valid, out_ready, out_data| out       | slir_pkg::out_t (status, count,
//         |                              |           |   smallest, largest)
//
// one command at a time; the entry store is a memory with one read and one write port
// insert: scans down from the tail, moving each entry not less than the value up one place; full: STAT_FULL
// remove: scans every stored entry, moving each entry after the first match down one place
// reset (rst_n low, synchronous) empties the list; store contents stay undefined
// a result waiting in the output register does not block the next command transfer,
// but that command holds in its last state until the register is free

module sorted_list_insert_remove_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  slir_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output slir_pkg::out_t  out_data
);

  logic signed [31:0] mem [slir_pkg::CAPACITY];
  logic signed [31:0] rdata_r;

  slir_pkg::state_t             state_r, state_nxt;
  logic [slir_pkg::CNT_W-1:0]   fill_r, fill_nxt;
  logic [slir_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic                         found_r, found_nxt;
  slir_pkg::cmd_t               cmd_r, cmd_nxt;
  logic signed [31:0]           val_r, val_nxt;
  slir_pkg::status_t            status_r, status_nxt;
  logic signed [31:0]           head_r, head_nxt;
  logic                         out_valid_r, out_valid_nxt;
  slir_pkg::out_t               out_data_r, out_data_nxt;

  logic                         mem_we;
  logic [slir_pkg::ADDR_W-1:0]  mem_wa;
  logic signed [31:0]           mem_wd;
  logic [slir_pkg::ADDR_W-1:0]  mem_ra;

  logic [slir_pkg::CNT_W-1:0]   idx_dec, idx_inc, fill_dec;
  logic                         rd_less, rd_equal, out_free;

  assign idx_dec  = idx_r - 1'b1;
  assign idx_inc  = idx_r + 1'b1;
  assign fill_dec = fill_r - 1'b1;
  assign rd_less  = rdata_r < val_r;
  assign rd_equal = rdata_r == val_r;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      slir_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.command;
          val_nxt   = in_data.value;
          found_nxt = 1'b0;
          if (in_data.command == slir_pkg::CMD_INSERT) begin
            idx_nxt = fill_r;
            if (fill_r == slir_pkg::CNT_W'(slir_pkg::CAPACITY)) begin
              status_nxt = slir_pkg::STAT_FULL;
              state_nxt  = slir_pkg::ST_HEAD;
            end else if (fill_r == '0) begin
              state_nxt = slir_pkg::ST_INS_PUT;
            end else begin
              state_nxt = slir_pkg::ST_INS_RD;
            end
          end else begin
            idx_nxt = '0;
            if (fill_r == '0) begin
              status_nxt = slir_pkg::STAT_NOT_FOUND;
              state_nxt  = slir_pkg::ST_HEAD;
            end else begin
              state_nxt = slir_pkg::ST_REM_RD;
            end
          end
        end
      end
      slir_pkg::ST_INS_RD: begin
        state_nxt = slir_pkg::ST_INS_CMP;
      end
      slir_pkg::ST_INS_CMP: begin
        if (rd_less) begin
          fill_nxt   = fill_r + 1'b1;
          status_nxt = slir_pkg::STAT_INSERTED;
          state_nxt  = slir_pkg::ST_HEAD;
        end else begin
          idx_nxt   = idx_dec;
          state_nxt = (idx_dec == '0) ? slir_pkg::ST_INS_PUT : slir_pkg::ST_INS_RD;
        end
      end
      slir_pkg::ST_INS_PUT: begin
        fill_nxt   = fill_r + 1'b1;
        status_nxt = slir_pkg::STAT_INSERTED;
        state_nxt  = slir_pkg::ST_HEAD;
      end
      slir_pkg::ST_REM_RD: begin
        state_nxt = slir_pkg::ST_REM_CMP;
      end
      slir_pkg::ST_REM_CMP: begin
        if (!found_r && rd_equal) begin
          found_nxt = 1'b1;
        end
        idx_nxt = idx_inc;
        if (idx_r == fill_dec) begin
          if (found_r || rd_equal) begin
            fill_nxt   = fill_dec;
            status_nxt = slir_pkg::STAT_REMOVED;
          end else begin
            status_nxt = slir_pkg::STAT_NOT_FOUND;
          end
          state_nxt = slir_pkg::ST_HEAD;
        end else begin
          state_nxt = slir_pkg::ST_REM_RD;
        end
      end
      slir_pkg::ST_HEAD: begin
        state_nxt = (fill_r == '0) ? slir_pkg::ST_FIN : slir_pkg::ST_TAIL;
      end
      slir_pkg::ST_TAIL: begin
        head_nxt  = rdata_r;
        state_nxt = slir_pkg::ST_TAIL_WAIT;
      end
      slir_pkg::ST_TAIL_WAIT: begin
        state_nxt = slir_pkg::ST_FIN;
      end
      slir_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.status   = status_r;
          out_data_nxt.count    = 5'(fill_r);
          out_data_nxt.smallest = (fill_r == '0) ? '0 : head_r;
          out_data_nxt.largest  = (fill_r == '0) ? '0 : rdata_r;
          state_nxt             = slir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = slir_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = idx_r[slir_pkg::ADDR_W-1:0];
    mem_wd   = val_r;
    mem_ra   = idx_r[slir_pkg::ADDR_W-1:0];
    case (state_r)
      slir_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      slir_pkg::ST_INS_RD: begin
        mem_ra = idx_dec[slir_pkg::ADDR_W-1:0];
      end
      slir_pkg::ST_INS_CMP: begin
        mem_we = 1'b1;
        mem_wd = rd_less ? val_r : rdata_r;
      end
      slir_pkg::ST_INS_PUT: begin
        mem_we = 1'b1;
      end
      slir_pkg::ST_REM_CMP: begin
        mem_we = found_r;
        mem_wa = idx_dec[slir_pkg::ADDR_W-1:0];
        mem_wd = rdata_r;
      end
      slir_pkg::ST_HEAD: begin
        mem_ra = '0;
      end
      slir_pkg::ST_TAIL: begin
        mem_ra = fill_dec[slir_pkg::ADDR_W-1:0];
      end
      // keep the tail entry on the read data until the result is loaded into the output register
      slir_pkg::ST_TAIL_WAIT: begin
        mem_ra = fill_dec[slir_pkg::ADDR_W-1:0];
      end
      slir_pkg::ST_FIN: begin
        mem_ra = fill_dec[slir_pkg::ADDR_W-1:0];
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slir_pkg::ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    head_r     <= head_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= slir_pkg::CNT_W'(slir_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == slir_pkg::STAT_FULL
      |-> out_data_r.count == 5'(slir_pkg::CAPACITY))
    else $error("full status with list not full");

  a_insert_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == slir_pkg::STAT_INSERTED |-> out_data_r.count != '0)
    else $error("insert left list empty");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.count == '0
      |-> out_data_r.smallest == '0 && out_data_r.largest == '0)
    else $error("empty list reports nonzero bounds");

  a_ins_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == slir_pkg::ST_INS_CMP || state_r == slir_pkg::ST_INS_RD
      |-> cmd_r == slir_pkg::CMD_INSERT && idx_r != '0 && idx_r <= fill_r)
    else $error("insert scan index out of range");

endmodule
